// ===== hw/rtl/twq_pkg.sv =====
package twq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned QAW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QSUM_W = QAW + 1;
  localparam int unsigned QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RCW    = $clog2(MAX_RESULTS + 1);

  localparam int unsigned TIME_W = 64;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned PRIO_W = 6;
  localparam int unsigned DUR_W  = 32;

  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 16;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  localparam logic STATUS_WOKEN = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_INSERT,
    ST_FULL,
    ST_WAKE_RD,
    ST_WAKE_CHK
  } state_e;

  // physical slot of a logical queue position, circular from head
  function automatic logic [QAW-1:0] twq_slot(input logic [QAW-1:0] head,
                                              input logic [QAW-1:0] idx);
    logic [QSUM_W-1:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= QSUM_W'(QUEUE_DEPTH)) begin
      sum = sum - QSUM_W'(QUEUE_DEPTH);
    end
    return sum[QAW-1:0];
  endfunction

endpackage

// ===== hw/rtl/twq_ram.sv =====
module twq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/timed_wakeup_queue_unit.sv =====
// sleep transfer: written straight into an empty queue, else later entries move up a slot
// tick transfer: advances the counter, then wakes due entries from the head in order;
// one ram read and compare per entry, and a result may wait on m_axis_tready_i
// queue full: the result waits in ST_FULL until the output register is free.
// reset clears the tick counter, occupancy, head pointer and control state;
// the entry ram holds no reset value and is only read below occupancy
module timed_wakeup_queue_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // thread_id, thread_priority, sleep_duration, current_priority, zero pad
  input  logic [twq_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // operation
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // woken_thread, yield_request, zero pad
  output logic [twq_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // status
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import twq_pkg::*;

  state_e            state_q, state_d;
  logic [TIME_W-1:0] count_q, count_d;
  logic [QAW-1:0]    head_q, head_d;
  logic [QCW-1:0]    occ_q, occ_d;
  logic [QAW-1:0]    idx_q, idx_d;
  entry_t            new_q, new_d;
  logic [PRIO_W-1:0] cur_q, cur_d;
  logic [RCW-1:0]    n_q, n_d;
  logic              held_valid_q, held_valid_d;
  logic [ID_W-1:0]   held_id_q, held_id_d;
  logic              held_yield_q, held_yield_d;
  logic              out_valid_q, out_valid_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic              out_yield_q, out_yield_d;
  logic              out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  logic              ram_we, ram_re;
  logic [QAW-1:0]    ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  logic [ID_W-1:0]   in_id;
  logic [PRIO_W-1:0] in_prio;
  logic [DUR_W-1:0]  in_dur;
  logic [PRIO_W-1:0] in_cur;
  logic              out_free;

  assign in_id   = s_axis_tdata_i[ID_W-1:0];
  assign in_prio = s_axis_tdata_i[ID_W+PRIO_W-1:ID_W];
  assign in_dur  = s_axis_tdata_i[ID_W+PRIO_W+DUR_W-1:ID_W+PRIO_W];
  assign in_cur  = s_axis_tdata_i[ID_W+2*PRIO_W+DUR_W-1:ID_W+PRIO_W+DUR_W];

  assign out_free = !out_valid_q || m_axis_tready_i;

  twq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    occ_d        = occ_q;
    idx_d        = idx_q;
    new_d        = new_q;
    cur_d        = cur_q;
    n_d          = n_q;
    held_valid_d = held_valid_q;
    held_id_d    = held_id_q;
    held_yield_d = held_yield_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_id_d     = out_id_q;
    out_yield_d  = out_yield_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = twq_slot(head_q, idx_q);
    ram_wdata    = new_q;
    ram_re       = 1'b0;
    ram_raddr    = head_q;
    s_axis_tready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == OP_SLEEP) begin
            if (in_dur != '0 && !in_dur[DUR_W-1]) begin
              new_d.wake = count_q + {{(TIME_W-DUR_W){1'b0}}, in_dur};
              new_d.id   = in_id;
              new_d.prio = in_prio;
              if (occ_q == QCW'(QUEUE_DEPTH)) begin
                state_d = ST_FULL;
              end else if (occ_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = head_q;
                ram_wdata = new_d;
                occ_d     = occ_q + QCW'(1);
              end else begin
                idx_d     = QAW'(occ_q - QCW'(1));
                ram_re    = 1'b1;
                ram_raddr = twq_slot(head_q, idx_d);
                state_d   = ST_SHIFT;
              end
            end
          end else begin
            count_d      = count_q + TIME_W'(1);
            cur_d        = in_cur;
            n_d          = '0;
            held_valid_d = 1'b0;
            state_d      = ST_WAKE_RD;
          end
        end
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = twq_slot(head_q, idx_q + QAW'(1));
        if (ram_rdata.wake > new_q.wake) begin
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = ST_INSERT;
          end else begin
            idx_d     = idx_q - QAW'(1);
            ram_re    = 1'b1;
            ram_raddr = twq_slot(head_q, idx_d);
          end
        end else begin
          ram_wdata = new_q;
          occ_d     = occ_q + QCW'(1);
          state_d   = ST_IDLE;
        end
      end
      ST_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = head_q;
        ram_wdata = new_q;
        occ_d     = occ_q + QCW'(1);
        state_d   = ST_IDLE;
      end
      ST_FULL: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_id_d     = '0;
          out_yield_d  = 1'b0;
          out_status_d = STATUS_FULL;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_WAKE_RD: begin
        if (occ_q == '0 || n_q == RCW'(MAX_RESULTS)) begin
          if (!held_valid_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_valid_d  = 1'b1;
            out_id_d     = held_id_q;
            out_yield_d  = held_yield_q;
            out_status_d = STATUS_WOKEN;
            out_last_d   = 1'b1;
            held_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = head_q;
          state_d   = ST_WAKE_CHK;
        end
      end
      ST_WAKE_CHK: begin
        if (ram_rdata.wake <= count_q) begin
          if (!held_valid_q || out_free) begin
            if (held_valid_q) begin
              out_valid_d  = 1'b1;
              out_id_d     = held_id_q;
              out_yield_d  = held_yield_q;
              out_status_d = STATUS_WOKEN;
              out_last_d   = 1'b0;
            end
            held_valid_d = 1'b1;
            held_id_d    = ram_rdata.id;
            held_yield_d = ram_rdata.prio > cur_q;
            head_d       = twq_slot(head_q, QAW'(1));
            occ_d        = occ_q - QCW'(1);
            n_d          = n_q + RCW'(1);
            state_d      = ST_WAKE_RD;
          end
        end else begin
          if (!held_valid_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_valid_d  = 1'b1;
            out_id_d     = held_id_q;
            out_yield_d  = held_yield_q;
            out_status_d = STATUS_WOKEN;
            out_last_d   = 1'b1;
            held_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      head_q       <= '0;
      occ_q        <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      head_q       <= head_d;
      occ_q        <= occ_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    new_q        <= new_d;
    cur_q        <= cur_d;
    n_q          <= n_d;
    held_id_q    <= held_id_d;
    held_yield_q <= held_yield_d;
    out_id_q     <= out_id_d;
    out_yield_q  <= out_yield_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W-ID_W-1){1'b0}}, out_yield_q, out_id_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= QCW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_tick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OP_TICK
    |=> count_q == $past(count_q) + TIME_W'(1))
    else $error("tick transfer did not advance the counter");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STATUS_FULL
    |-> m_axis_tlast_o && m_axis_tdata_o == '0)
    else $error("queue full result malformed");

  a_sorted_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAKE_CHK && held_valid_q |-> n_q != '0)
    else $error("held result without a woken entry");
`endif

endmodule

// ===== tb/sv/tb_timed_wakeup_queue_unit.sv =====
module tb_timed_wakeup_queue_unit;
  import twq_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef struct {
    logic              op;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [DUR_W-1:0]  dur;
    logic [PRIO_W-1:0] cur;
  } twq_req_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            yld;
    logic            status;
    logic            last;
  } wake_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_valid;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_data;
  logic                  s_user;
  logic                  m_axis_tvalid_o;
  logic                  m_ready;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  // predictor state
  logic [TIME_W-1:0] tick_count;
  entry_t            sleepers[$];
  wake_result_t      pending_wakeups[$];

  bit          s_calm;
  bit          m_calm;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned full_seen;
  int unsigned peak_occupancy;
  int unsigned biggest_burst;

  timed_wakeup_queue_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 92) return $urandom_range(4, 8);
    else return $urandom_range(15, 40);
  endfunction

  // expected results of one accepted transfer
  task automatic predict_wakeups(input twq_req_t req);
    wake_result_t burst[$];
    wake_result_t r;
    entry_t       e;
    int unsigned  pos;
    if (req.op == OP_SLEEP) begin
      if ($signed(req.dur) <= 0) return;
      if (sleepers.size() >= QUEUE_DEPTH) begin
        r.id = '0;
        r.yld = 1'b0;
        r.status = STATUS_FULL;
        r.last = 1'b1;
        pending_wakeups.push_back(r);
        return;
      end
      e.wake = tick_count + TIME_W'(req.dur);
      e.id = req.id;
      e.prio = req.prio;
      pos = 0;
      while (pos < sleepers.size() && sleepers[pos].wake <= e.wake) pos++;
      sleepers.insert(pos, e);
      if (sleepers.size() > peak_occupancy) peak_occupancy = sleepers.size();
    end else begin
      tick_count = tick_count + 1;
      while (burst.size() < MAX_RESULTS && sleepers.size() > 0 &&
             sleepers[0].wake <= tick_count) begin
        e = sleepers.pop_front();
        r.id = e.id;
        r.yld = (e.prio > req.cur);
        r.status = STATUS_WOKEN;
        r.last = 1'b0;
        burst.push_back(r);
      end
      if (burst.size() > 0) begin
        burst[burst.size()-1].last = 1'b1;
        if (burst.size() > biggest_burst) biggest_burst = burst.size();
      end
      foreach (burst[i]) pending_wakeups.push_back(burst[i]);
    end
  endtask

  // enters and leaves at a falling edge
  task automatic send_item(input logic op, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio, input logic [DUR_W-1:0] dur,
                           input logic [PRIO_W-1:0] cur);
    twq_req_t    req;
    int unsigned gap;
    req.op = op;
    req.id = id;
    req.prio = prio;
    req.dur = dur;
    req.cur = cur;
    gap = (s_calm || $urandom_range(0, 1)) ? 0 : pick_gap_len();
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_user = op;
    s_data = {{(S_TDATA_W-ID_W-2*PRIO_W-DUR_W){1'b0}}, cur, dur, prio, id};
    s_valid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_wakeups(req);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_tick(input logic [PRIO_W-1:0] cur);
    send_item(OP_TICK, ID_W'($urandom), PRIO_W'($urandom), DUR_W'($urandom), cur);
  endtask

  task automatic send_sleep(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio,
                            input logic [DUR_W-1:0] dur);
    send_item(OP_SLEEP, id, prio, dur, PRIO_W'($urandom));
  endtask

  task automatic test_tick_on_empty();
    send_tick(6'd63);
    send_tick(6'd0);
  endtask

  task automatic test_ignored_durations();
    send_sleep(8'h11, 6'd5, 32'd0);
    send_sleep(8'h22, 6'd5, 32'hffff_ffff);
    send_sleep(8'h33, 6'd5, 32'h8000_0000);
  endtask

  task automatic test_equal_wake_order();
    send_sleep(8'h01, 6'd63, 32'd2);
    send_sleep(8'hff, 6'd0, 32'd2);
    send_sleep(8'haa, 6'd32, 32'd1);
    send_tick(6'd31);
    send_tick(6'd0);
  endtask

  task automatic test_full_and_burst();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_sleep(ID_W'(i * 17), PRIO_W'(i * 4 + 3), 32'd1);
    end
    send_sleep(8'h5a, 6'd40, 32'd3);
    send_tick(6'd30);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned sleep_pct;
    int unsigned r;
    logic [DUR_W-1:0] dur;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        r = $urandom_range(0, 2);
        sleep_pct = (r == 0) ? 30 : (r == 1) ? 55 : 80;
        s_calm = ($urandom_range(0, 3) == 0);
        m_calm = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < sleep_pct) begin
        r = $urandom_range(0, 99);
        if (r < 70) dur = $urandom_range(1, 6);
        else if (r < 90) dur = $urandom_range(7, 40);
        else if (r < 95) dur = $urandom_range(41, 200);
        else if (r < 97) dur = '0;
        else dur = $urandom | 32'h8000_0000;
        send_sleep(ID_W'($urandom), PRIO_W'($urandom), dur);
      end else begin
        send_tick(PRIO_W'($urandom));
      end
    end
    s_calm = 1'b0;
    m_calm = 1'b0;
  endtask

  // sleepers that never wake, so done last
  task automatic test_long_sleepers();
    while (sleepers.size() > 0) send_tick(PRIO_W'($urandom));
    send_sleep(8'hff, 6'd63, 32'h7fff_ffff);
    send_sleep(8'h00, 6'd0, 32'h4000_0000);
    for (int i = 2; i < QUEUE_DEPTH; i++) begin
      send_sleep(ID_W'($urandom), PRIO_W'($urandom), ($urandom | 32'h4000_0000) & 32'h7fff_ffff);
    end
    send_sleep(8'h77, 6'd12, 32'h7fff_ffff);
    send_sleep(8'h78, 6'd12, 32'd1);
    send_tick(6'd63);
  endtask

  initial begin : output_stall
    m_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_ready = 1'b0;
        stall_left--;
      end else begin
        m_ready = 1'b1;
        if (!m_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap_len();
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    wake_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      results_seen++;
      if (m_axis_tuser_o == STATUS_FULL) full_seen++;
      if (pending_wakeups.size() == 0) begin
        $error("result with nothing expected: woken_thread %0h status %0b",
               m_axis_tdata_o[ID_W-1:0], m_axis_tuser_o);
        err_cnt++;
      end else begin
        want = pending_wakeups.pop_front();
        if (m_axis_tdata_o[ID_W-1:0] !== want.id) begin
          $error("woken_thread: expected %0h, got %0h", want.id, m_axis_tdata_o[ID_W-1:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[ID_W] !== want.yld) begin
          $error("yield_request: expected %0b, got %0b", want.yld, m_axis_tdata_o[ID_W]);
          err_cnt++;
        end
        if (m_axis_tuser_o !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, m_axis_tuser_o);
          err_cnt++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[timed_wakeup_queue_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_valid = 1'b0;
    s_user = OP_TICK;
    s_data = '0;
    s_calm = 1'b0;
    m_calm = 1'b0;
    tick_count = '0;
    idle_cycles = 0;
    err_cnt = 0;
    items_sent = 0;
    results_seen = 0;
    full_seen = 0;
    peak_occupancy = 0;
    biggest_burst = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_tick_on_empty();
    test_ignored_durations();
    test_equal_wake_order();
    test_full_and_burst();
    test_random_traffic(420);
    test_long_sleepers();
    s_valid = 1'b0;

    while (pending_wakeups.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_wakeups.size() != 0) begin
      $error("%0d expected results never arrived", pending_wakeups.size());
      err_cnt++;
    end

    $display("sent %0d requests over %0d ticks, checked %0d results (%0d queue-full drops)",
             items_sent, tick_count, results_seen, full_seen);
    $display("peak occupancy %0d, largest wake burst %0d", peak_occupancy, biggest_burst);
    if (err_cnt == 0) begin
      $display("[timed_wakeup_queue_unit] OK");
    end else begin
      $display("[timed_wakeup_queue_unit] ERROR");
    end
    $finish;
  end

endmodule
